// ===== hw/rtl/rmmcs_pkg.sv =====
`default_nettype none

package rmmcs_pkg;

    localparam int CH_W      = 8;
    localparam int CH_NUM    = 3;
    localparam int NUM_W     = 2 * CH_W;
    localparam int DIV_STEPS = CH_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef logic [CH_W-1:0]              t_pix;
    typedef logic [CH_NUM-1:0][CH_W-1:0]  t_rgb;
    typedef logic [1:0]                   t_ch;
    typedef logic [NUM_W-1:0]             t_num;

    localparam t_ch CH_RED   = 2'd0;
    localparam t_ch CH_GREEN = 2'd1;
    localparam t_ch CH_BLUE  = 2'd2;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_STRETCH = 1'b1;

    localparam t_pix CHANNEL_MAX = 8'd255;
    localparam t_pix CHANNEL_MIN = 8'd0;

    // statistics update request
    typedef struct packed {
        logic update;
        logic restart;
    } t_obs_req;

    // divider launch
    typedef struct packed {
        logic start;
        t_num num;
        t_pix span;
    } t_div_req;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_min_max_contrast_stretch.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_opcode, i_first_of_image,
//                                                 i_red_in, i_green_in, i_blue_in
// out       output     o_out_valid / i_out_stall  o_red_out, o_green_out, o_blue_out
//
// An observe transfer is absorbed in the cycle it is accepted; the next
// transfer can follow at once. A stretch transfer runs the three channels in
// turn through one shared 8-step restoring divider: a channel takes a setup
// state plus the divide steps, or only the setup state when its span is
// empty; the next input is taken in the cycle after the result is pushed.
// Reset is synchronous, active low, and puts the statistics at low = 255,
// high = 0. A stalled output holds its result; a finished result waits for
// the output register to empty.
module rgb_min_max_contrast_stretch (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_opcode,
    input  logic                 i_first_of_image,
    input  rmmcs_pkg::t_pix      i_red_in,
    input  rmmcs_pkg::t_pix      i_green_in,
    input  rmmcs_pkg::t_pix      i_blue_in,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rmmcs_pkg::t_pix      o_red_out,
    output rmmcs_pkg::t_pix      o_green_out,
    output rmmcs_pkg::t_pix      o_blue_out
);
    import rmmcs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0] r_state, n_state;
    t_ch        r_ch, n_ch;
    t_rgb       r_pix;      // captured stretch sample
    t_rgb       r_res;      // per-channel results as they finish
    t_rgb       r_out;
    logic       r_out_valid;

    logic       in_xfer;
    logic       out_xfer;
    logic       push;
    t_rgb       in_pix;
    t_rgb       low, high;
    t_obs_req   obs_req;
    t_div_req   div_req;
    t_div_stat  div_stat;
    t_pix       quot;

    // current channel operands
    t_pix       cur_v, cur_lo, cur_hi, cur_clamp, cur_d;
    logic       cur_empty;
    logic       ch_done;
    t_pix       ch_res;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign push     = (r_state == ST_PUSH) && (!r_out_valid || !i_out_stall);

    assign in_pix[CH_RED]   = i_red_in;
    assign in_pix[CH_GREEN] = i_green_in;
    assign in_pix[CH_BLUE]  = i_blue_in;

    // Observe transfers go straight into the statistics.
    assign obs_req.update  = in_xfer && (i_opcode == OP_OBSERVE);
    assign obs_req.restart = i_first_of_image;

    rmmcs_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_obs   (obs_req),
        .i_pix   (in_pix),
        .o_low   (low),
        .o_high  (high)
    );

    // Clamp the sample into [low, high] and form 255 * (v - low) as
    // (d << 8) - d. An empty span passes the raw sample through.
    assign cur_v     = r_pix[r_ch];
    assign cur_lo    = low[r_ch];
    assign cur_hi    = high[r_ch];
    assign cur_empty = (cur_hi <= cur_lo);
    assign cur_clamp = (cur_v < cur_lo) ? cur_lo : ((cur_v > cur_hi) ? cur_hi : cur_v);
    assign cur_d     = cur_clamp - cur_lo;

    assign div_req.start = (r_state == ST_SETUP) && !cur_empty;
    assign div_req.num   = {cur_d, CH_W'(0)} - {CH_W'(0), cur_d};
    assign div_req.span  = cur_hi - cur_lo;

    rmmcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat),
        .o_quot  (quot)
    );

    // A channel finishes either on an empty span in setup or when the
    // divider delivers its last quotient bit.
    assign ch_done = ((r_state == ST_SETUP) && cur_empty) ||
                     ((r_state == ST_DIV) && div_stat.done);
    assign ch_res  = (r_state == ST_SETUP) ? cur_v : quot;

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && (i_opcode == OP_STRETCH)) begin
                    n_state = ST_SETUP;
                    n_ch    = CH_RED;
                end
            end
            ST_SETUP: begin
                if (!cur_empty) begin
                    n_state = ST_DIV;
                end else if (r_ch == CH_BLUE) begin
                    n_state = ST_PUSH;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (r_ch == CH_BLUE) begin
                        n_state = ST_PUSH;
                    end else begin
                        n_state = ST_SETUP;
                        n_ch    = r_ch + 1'b1;
                    end
                end
            end
            ST_PUSH: begin
                if (push) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ch        <= CH_RED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            // load a fresh result, or drop the old one once it is taken
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pix <= in_pix;
        end
        if (ch_done) begin
            r_res[r_ch] <= ch_res;
        end
        if (push) begin
            r_out <= r_res;
        end
    end

    // Only an idle sequencer takes the next transfer.
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_out[CH_RED];
    assign o_green_out = r_out[CH_GREEN];
    assign o_blue_out  = r_out[CH_BLUE];

    // A stretch transfer must lock out the input on the next cycle.
    a_stretch_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_opcode == OP_STRETCH) |=> o_in_stall)
        else $error("stretch transfer did not block the input");

    // The divider runs only while the sequencer waits on it.
    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == ST_DIV))
        else $error("divider busy outside the divide state");

    // A divide state always has the divider working.
    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> div_stat.busy)
        else $error("divide state without a running divider");

    // Never overwrite a result that is still stalled at the output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!r_out_valid || !i_out_stall))
        else $error("output result overwritten while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/rmmcs_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees
// num < 256 * span, so the quotient fits in eight bits and eight steps suffice.
module rmmcs_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmmcs_pkg::t_div_req   i_req,
    output rmmcs_pkg::t_div_stat  o_stat,
    output rmmcs_pkg::t_pix       o_quot
);
    import rmmcs_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    t_pix              r_rem;
    t_pix              r_acc;   // low dividend bits out, quotient bits in
    t_pix              r_span;

    logic [CH_W:0]     trial;
    logic [CH_W:0]     diff;
    logic              qbit;
    t_pix              rem_next;
    logic              last;

    assign trial    = {r_rem, r_acc[CH_W-1]};
    assign diff     = trial - {1'b0, r_span};
    assign qbit     = (trial >= {1'b0, r_span});
    assign rem_next = qbit ? diff[CH_W-1:0] : trial[CH_W-1:0];
    assign last     = (r_cnt == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num[NUM_W-1:CH_W];
            r_acc  <= i_req.num[CH_W-1:0];
            r_span <= i_req.span;
        end else if (r_busy) begin
            r_rem <= rem_next;
            r_acc <= {r_acc[CH_W-2:0], qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && last;
    assign o_quot      = {r_acc[CH_W-2:0], qbit};

endmodule

`default_nettype wire

// ===== hw/rtl/rmmcs_stats.sv =====
`default_nettype none

// Running per-channel minimum and maximum.
module rmmcs_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rmmcs_pkg::t_obs_req  i_obs,
    input  rmmcs_pkg::t_rgb      i_pix,
    output rmmcs_pkg::t_rgb      o_low,
    output rmmcs_pkg::t_rgb      o_high
);
    import rmmcs_pkg::*;

    t_rgb r_low;
    t_rgb r_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CH_NUM; c++) begin
                r_low[c]  <= CHANNEL_MAX;
                r_high[c] <= CHANNEL_MIN;
            end
        end else if (i_obs.update) begin
            for (int c = 0; c < CH_NUM; c++) begin
                if (i_obs.restart || (i_pix[c] < r_low[c])) begin
                    r_low[c] <= i_pix[c];
                end
                if (i_obs.restart || (i_pix[c] > r_high[c])) begin
                    r_high[c] <= i_pix[c];
                end
            end
        end
    end

    assign o_low  = r_low;
    assign o_high = r_high;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

import rmmcs_pkg::*;

class pixel_stretch_board;
    t_rgb   low_seen;
    t_rgb   high_seen;
    t_rgb   stretched_due[$];
    string  field_name[CH_NUM];
    int     mismatches;

    function new();
        low_seen   = {CH_NUM{CHANNEL_MAX}};
        high_seen  = {CH_NUM{CHANNEL_MIN}};
        mismatches = 0;
        field_name[CH_RED]   = "red_out";
        field_name[CH_GREEN] = "green_out";
        field_name[CH_BLUE]  = "blue_out";
    endfunction

    // floor(255 * (v - low) / (high - low)) after clamping, or v when the span is empty
    function t_pix stretch_channel(t_pix lo, t_pix hi, t_pix v);
        t_pix        clamped;
        int unsigned span;
        int unsigned scaled;
        if (hi <= lo) return v;
        clamped = (v < lo) ? lo : ((v > hi) ? hi : v);
        span    = int'(hi) - int'(lo);
        scaled  = int'(CHANNEL_MAX) * (int'(clamped) - int'(lo));
        return t_pix'(scaled / span);
    endfunction

    function void note_pixel(logic op, logic first, t_rgb px);
        t_rgb due;
        if (op == OP_OBSERVE) begin
            for (int c = 0; c < CH_NUM; c++) begin
                if (first) begin
                    low_seen[c]  = px[c];
                    high_seen[c] = px[c];
                end else begin
                    if (px[c] < low_seen[c])  low_seen[c]  = px[c];
                    if (px[c] > high_seen[c]) high_seen[c] = px[c];
                end
            end
        end else begin
            for (int c = 0; c < CH_NUM; c++)
                due[c] = stretch_channel(low_seen[c], high_seen[c], px[c]);
            stretched_due.push_back(due);
        end
    endfunction

    function void check_pixel(t_rgb got);
        t_rgb due;
        if (stretched_due.size() == 0) begin
            $error("stretched pixel %h arrived with none pending", got);
            mismatches++;
            return;
        end
        due = stretched_due.pop_front();
        for (int c = 0; c < CH_NUM; c++) begin
            if (got[c] !== due[c]) begin
                $error("%s: expected %0d, got %0d", field_name[c], due[c], got[c]);
                mismatches++;
            end
        end
    endfunction

    function int pending();
        return stretched_due.size();
    endfunction
endclass

module tb_top;

    localparam int ITEM_TARGET = 950;
    localparam int CYCLE_LIMIT = 400000;
    // margin beyond the longest stretch and its hand-off
    localparam int DRAIN_CYCLES = 40;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    logic   i_opcode = OP_OBSERVE;
    logic   i_first_of_image = 1'b0;
    t_pix   i_red_in = '0;
    t_pix   i_green_in = '0;
    t_pix   i_blue_in = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_pix   o_red_out;
    t_pix   o_green_out;
    t_pix   o_blue_out;

    pixel_stretch_board board = new();

    // set while a stretch of items runs with both sides at full speed
    bit     calm = 1'b0;
    int     items_sent = 0;
    int     cycles = 0;

    rgb_min_max_contrast_stretch u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_first_of_image (i_first_of_image),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_red_out        (o_red_out),
        .o_green_out      (o_green_out),
        .o_blue_out       (o_blue_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_rgb pack_rgb(t_pix r, t_pix g, t_pix b);
        t_rgb px;
        px[CH_RED]   = r;
        px[CH_GREEN] = g;
        px[CH_BLUE]  = b;
        return px;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 25);
    endfunction

    // Watch both channels at the edge. Everything the bench drives changes
    // through nonblocking assignments, so the values read here are the ones
    // the block saw at this same edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            board.note_pixel(i_opcode, i_first_of_image,
                             pack_rgb(i_red_in, i_green_in, i_blue_in));
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_pixel(pack_rgb(o_red_out, o_green_out, o_blue_out));
    end

    // Receiver: stall about a quarter of the cycles, never during the calm window.
    always @(posedge i_clk)
        i_out_stall <= take_break();

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** rgb_min_max_contrast_stretch: FAILED **");
            $finish;
        end
    end

    // Offer one pixel and hold it until the block takes the transfer.
    // Leave valid high on return so a back-to-back item needs no second
    // assignment in the same step.
    task automatic send_pixel(logic op, logic first, t_pix r, t_pix g, t_pix b);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_first_of_image <= first;
        i_red_in         <= r;
        i_green_in       <= g;
        i_blue_in        <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        // full-speed window somewhere in the middle of the random part
        calm = (items_sent >= 400 && items_sent < 560);
    endtask

    // Pick a sample inside [base, base + reach], or anywhere now and then
    // so the clamp on both sides gets exercised.
    function automatic t_pix pick_sample(t_pix base, t_pix reach, bit stray);
        if (stray) return t_pix'($urandom_range(255));
        return t_pix'(int'(base) + $urandom_range(int'(reach)));
    endfunction

    // One image: an observe pass that usually opens with a restart, then a stretch pass.
    task automatic send_image();
        t_pix base[CH_NUM];
        t_pix reach[CH_NUM];
        int   n_observe;
        int   n_stretch;
        logic restart;
        t_pix px[CH_NUM];
        for (int c = 0; c < CH_NUM; c++) begin
            case ($urandom_range(3))
                0: reach[c] = '0;                          // empty span
                1: reach[c] = t_pix'($urandom_range(1, 8));
                2: reach[c] = t_pix'($urandom_range(9, 64));
                default: reach[c] = t_pix'($urandom_range(255));
            endcase
            base[c] = t_pix'($urandom_range(255 - int'(reach[c])));
        end
        n_observe = $urandom_range(1, 12);
        n_stretch = $urandom_range(1, 12);
        // now and then keep accumulating from the previous image
        restart = ($urandom_range(9) != 0);
        for (int i = 0; i < n_observe; i++) begin
            for (int c = 0; c < CH_NUM; c++)
                px[c] = pick_sample(base[c], reach[c], 1'b0);
            send_pixel(OP_OBSERVE, (i == 0) ? restart : 1'b0,
                       px[CH_RED], px[CH_GREEN], px[CH_BLUE]);
        end
        for (int i = 0; i < n_stretch; i++) begin
            for (int c = 0; c < CH_NUM; c++)
                px[c] = pick_sample(base[c], reach[c], $urandom_range(9) < 3);
            // the flag means nothing on a stretch; toggle it anyway
            send_pixel(OP_STRETCH, logic'($urandom_range(1)),
                       px[CH_RED], px[CH_GREEN], px[CH_BLUE]);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        // Nothing observed since reset: every span is empty, samples pass through.
        send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd128, 8'd255);
        // Restart, then widen: red 10..200, green and blue the full 0..255.
        send_pixel(OP_OBSERVE, 1'b1, 8'd10, 8'd0, 8'd255);
        send_pixel(OP_OBSERVE, 1'b0, 8'd200, 8'd255, 8'd0);
        // Red below and above its span gets clamped.
        send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(OP_STRETCH, 1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(OP_STRETCH, 1'b0, 8'd105, 8'd128, 8'd1);
        // Flag set on a stretch must not touch the statistics.
        send_pixel(OP_STRETCH, 1'b1, 8'd57, 8'd77, 8'd254);
        send_pixel(OP_STRETCH, 1'b0, 8'd57, 8'd77, 8'd254);
        // Restart to a single value: every span collapses to empty.
        send_pixel(OP_OBSERVE, 1'b1, 8'd100, 8'd100, 8'd100);
        send_pixel(OP_STRETCH, 1'b0, 8'd3, 8'd100, 8'd250);
        // Spans of one step on red and green; blue stays empty.
        send_pixel(OP_OBSERVE, 1'b0, 8'd101, 8'd99, 8'd100);
        send_pixel(OP_STRETCH, 1'b0, 8'd100, 8'd100, 8'd100);
        send_pixel(OP_STRETCH, 1'b0, 8'd101, 8'd99, 8'd255);
        // Opposite extremes per channel.
        send_pixel(OP_OBSERVE, 1'b1, 8'd255, 8'd0, 8'd128);
        send_pixel(OP_OBSERVE, 1'b0, 8'd254, 8'd1, 8'd127);
        send_pixel(OP_STRETCH, 1'b0, 8'd254, 8'd1, 8'd128);
        send_pixel(OP_STRETCH, 1'b0, 8'd0, 8'd255, 8'd0);
        send_pixel(OP_OBSERVE, 1'b1, 8'd0, 8'd255, 8'd0);
        send_pixel(OP_OBSERVE, 1'b0, 8'd255, 8'd0, 8'd255);
        send_pixel(OP_STRETCH, 1'b0, 8'd127, 8'd128, 8'd170);

        // Random part: mostly whole images, some raw noise in between.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(9) < 8) begin
                send_image();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_pixel(logic'($urandom_range(1)), logic'($urandom_range(1)),
                               t_pix'($urandom_range(255)), t_pix'($urandom_range(255)),
                               t_pix'($urandom_range(255)));
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain: wait for every stretched pixel, then watch for strays.
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("** rgb_min_max_contrast_stretch: PASSED **");
        end else begin
            $display("** rgb_min_max_contrast_stretch: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rmmcs_pkg.sv
hw/rtl/rmmcs_div.sv
hw/rtl/rmmcs_stats.sv
hw/rtl/rgb_min_max_contrast_stretch.sv
bench/tb_top.sv
